// ===== rtl/bbspi_pkg.sv =====
`default_nettype none

package bbspi_pkg;

   // Highest ADC channel that a read may address.
   localparam logic [3:0] MAX_CHANNEL = 4'd11;

   // Request opcodes. The fourth code is taken as a plain tick.
   localparam logic [1:0] OP_TICK     = 2'd0;
   localparam logic [1:0] OP_ADC_READ = 2'd1;
   localparam logic [1:0] OP_RAW_XFER = 2'd2;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPI_CLOCK_DIVIDER      = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRE_TRANSFER_ADC_EDGES = 2'd1;

   // Number of bits in one transfer.
   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   typedef enum logic [1:0] {
      PHASE_IDLE,
      PHASE_WAIT_RISE,
      PHASE_WAIT_FALL,
      PHASE_XFER
   } phase_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [3:0] channel;
      logic [7:0] tx_byte;
      logic       miso;
   } item_type;

   typedef struct packed {
      logic spi_sck;
      logic adc_sck;
      logic mosi;
      logic adc_select_n;
      logic rf_select_n;
      logic busy_res;
      logic done_res;
      logic [7:0] rx_byte;
      logic bad_channel;
   } result_type;

   typedef struct packed {
      logic [7:0] spi_clock_divider;
      logic [3:0] pre_transfer_adc_edges;
   } cfg_type;

   typedef struct packed {
      logic [7:0] div_count;
      logic       spi_level;
      logic       adc_level;
      logic       clock_enable;
      phase_type  phase;
      logic [3:0] wait_count;
      logic [3:0] bit_count;
      logic [7:0] shift_out;
      logic [7:0] shift_in;
      logic       select_level;
      logic       mosi_level;
   } state_type;

   localparam cfg_type CFG_RESET = '{
      spi_clock_divider:      8'd2,
      pre_transfer_adc_edges: 4'd4
   };

   localparam state_type STATE_RESET = '{
      div_count:    8'd0,
      spi_level:    1'b0,
      adc_level:    1'b0,
      clock_enable: 1'b0,
      phase:        PHASE_IDLE,
      wait_count:   4'd0,
      bit_count:    4'd0,
      shift_out:    8'd0,
      shift_in:     8'd0,
      select_level: 1'b1,
      mosi_level:   1'b0
   };

endpackage

`default_nettype wire

// ===== rtl/bbspi_if.sv =====
`default_nettype none

// Request channel: one timer tick with an optional start command.
interface bbspi_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [3:0] channel;
   logic [7:0] tx_byte;
   logic       miso;

   modport source (output valid, opcode, channel, tx_byte, miso, input ready);
   modport sink   (input valid, opcode, channel, tx_byte, miso, output ready);
endinterface

// Response channel: pin levels and status after one tick.
interface bbspi_rsp_if;
   logic       valid;
   logic       ready;
   logic       spi_sck;
   logic       adc_sck;
   logic       mosi;
   logic       adc_select_n;
   logic       rf_select_n;
   logic       busy_res;
   logic       done_res;
   logic [7:0] rx_byte;
   logic       bad_channel;

   modport source (output valid, spi_sck, adc_sck, mosi, adc_select_n, rf_select_n,
                   busy_res, done_res, rx_byte, bad_channel, input ready);
   modport sink   (input valid, spi_sck, adc_sck, mosi, adc_select_n, rf_select_n,
                   busy_res, done_res, rx_byte, bad_channel, output ready);
endinterface

// Configuration write channel.
interface bbspi_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/bbspi_rem_unit.sv =====
`default_nettype none

// Restoring remainder over the eight dividend bits, one quotient bit per cycle.
// Used to bring the tick counter below a newly written divider.
module bbspi_rem_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic [7:0] dividend,
   input  wire logic [7:0] divisor,
   output logic            busy,
   output logic            done,
   output logic [7:0]      remainder
);

   logic       run_ff;
   logic       done_ff;
   logic [2:0] step_ff;
   logic [7:0] rem_ff;
   logic [7:0] dividend_ff;
   logic [7:0] divisor_ff;

   logic [8:0] partial;
   logic [7:0] rem_in;

   // One shift-and-subtract step.
   always_comb begin
      partial = {rem_ff, dividend_ff[7]};
      if (partial >= {1'b0, divisor_ff}) begin
         rem_in = 8'(partial - {1'b0, divisor_ff});
      end else begin
         rem_in = partial[7:0];
      end
   end

   // Control: run flag, step counter and completion pulse.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 3'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= 3'd0;
         end else if (run_ff) begin
            step_ff <= step_ff + 3'd1;
            if (step_ff == 3'd7) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath. A zero divisor counts as one.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff      <= 8'd0;
         dividend_ff <= dividend;
         divisor_ff  <= (divisor == 8'd0) ? 8'd1 : divisor;
      end else if (run_ff) begin
         rem_ff      <= rem_in;
         dividend_ff <= {dividend_ff[6:0], 1'b0};
      end
   end

   assign busy      = run_ff | done_ff;
   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== rtl/bbspi_step.sv =====
`default_nettype none

// Next state and pin levels for one timer tick.
module bbspi_step (
   input  wire bbspi_pkg::state_type  state_cur,
   input  wire bbspi_pkg::cfg_type    cfg,
   input  wire bbspi_pkg::item_type   item,
   output bbspi_pkg::state_type  state_nxt,
   output bbspi_pkg::result_type result
);

   logic [7:0] eff_div;
   logic [8:0] count_inc;
   logic       spi_rise;
   logic       spi_fall;
   logic       adc_rise;
   logic       done;
   logic       bad;
   logic [7:0] rx;
   logic [3:0] wait_dec;

   always_comb begin
      state_nxt = state_cur;
      done      = 1'b0;
      bad       = 1'b0;
      rx        = 8'd0;
      spi_rise  = 1'b0;
      spi_fall  = 1'b0;
      eff_div   = (cfg.spi_clock_divider == 8'd0) ? 8'd1 : cfg.spi_clock_divider;
      count_inc = {1'b0, state_cur.div_count} + 9'd1;

      // Start commands are taken only while idle.
      if (state_cur.phase == bbspi_pkg::PHASE_IDLE) begin
         case (item.opcode)
            bbspi_pkg::OP_ADC_READ: begin
               if (item.channel > bbspi_pkg::MAX_CHANNEL) begin
                  bad = 1'b1;
               end else begin
                  state_nxt.select_level = 1'b0;
                  state_nxt.shift_out    = {item.channel, 4'd0};
                  state_nxt.wait_count   = cfg.pre_transfer_adc_edges;
                  state_nxt.phase        = (cfg.pre_transfer_adc_edges == 4'd0)
                                           ? bbspi_pkg::PHASE_WAIT_FALL
                                           : bbspi_pkg::PHASE_WAIT_RISE;
               end
            end
            bbspi_pkg::OP_RAW_XFER: begin
               state_nxt.shift_out    = item.tx_byte;
               state_nxt.shift_in     = 8'd0;
               state_nxt.bit_count    = 4'd0;
               state_nxt.mosi_level   = item.tx_byte[7];
               state_nxt.clock_enable = 1'b1;
               state_nxt.phase        = bbspi_pkg::PHASE_XFER;
            end
            default: begin
            end
         endcase
      end

      // Tick divider; the counter is kept below the effective divider.
      if (count_inc == {1'b0, eff_div}) begin
         state_nxt.div_count = 8'd0;
         if (state_cur.spi_level) begin
            state_nxt.spi_level = 1'b0;
            spi_fall            = 1'b1;
         end else if (state_nxt.clock_enable) begin
            state_nxt.spi_level = 1'b1;
            spi_rise            = 1'b1;
         end
      end else begin
         state_nxt.div_count = count_inc[7:0];
      end

      // The ADC clock toggles on every tick.
      state_nxt.adc_level = ~state_cur.adc_level;
      adc_rise            = state_nxt.adc_level;

      // The edge count may have been loaded by a start in this same tick.
      wait_dec = state_nxt.wait_count - 4'd1;

      // Sequence reacts to the edges of this tick.
      case (state_nxt.phase)
         bbspi_pkg::PHASE_WAIT_RISE: begin
            if (adc_rise) begin
               state_nxt.wait_count = wait_dec;
               if (wait_dec == 4'd0) begin
                  state_nxt.phase = bbspi_pkg::PHASE_WAIT_FALL;
               end
            end
         end
         bbspi_pkg::PHASE_WAIT_FALL: begin
            if (!adc_rise) begin
               state_nxt.shift_in     = 8'd0;
               state_nxt.bit_count    = 4'd0;
               state_nxt.mosi_level   = state_nxt.shift_out[7];
               state_nxt.clock_enable = 1'b1;
               state_nxt.phase        = bbspi_pkg::PHASE_XFER;
            end
         end
         bbspi_pkg::PHASE_XFER: begin
            if (spi_rise) begin
               state_nxt.shift_in  = {state_nxt.shift_in[6:0], item.miso};
               state_nxt.bit_count = state_nxt.bit_count + 4'd1;
            end else if (spi_fall) begin
               if (state_nxt.bit_count >= bbspi_pkg::BITS_PER_BYTE) begin
                  state_nxt.clock_enable = 1'b0;
                  state_nxt.spi_level    = 1'b0;
                  state_nxt.select_level = 1'b1;
                  state_nxt.phase        = bbspi_pkg::PHASE_IDLE;
                  done                   = 1'b1;
                  rx                     = state_nxt.shift_in;
               end else begin
                  state_nxt.mosi_level =
                     state_nxt.shift_out[3'(3'd7 - state_nxt.bit_count[2:0])];
               end
            end
         end
         default: begin
         end
      endcase

      result.spi_sck      = state_nxt.spi_level;
      result.adc_sck      = state_nxt.adc_level;
      result.mosi         = state_nxt.mosi_level;
      result.adc_select_n = state_nxt.select_level;
      result.rf_select_n  = 1'b1;
      result.busy_res     = (state_nxt.phase != bbspi_pkg::PHASE_IDLE);
      result.done_res     = done;
      result.rx_byte      = rx;
      result.bad_channel  = bad;
   end

endmodule

`default_nettype wire

// ===== rtl/bitbang_spi_adc_reader.sv =====
// A response is presented from the response register after its request has passed the tick step.
// Throughput: one request per cycle while the response is taken and no divider write is pending.
// A write of the SPI clock divider holds off requests and further writes
// while the tick counter is reduced modulo the new divider.
// Synchronous active-high reset: divider 2, edge wait 4, idle, ADC deselected.
`default_nettype none

module bitbang_spi_adc_reader (
   input  wire logic   clock,
   input  wire logic   reset,
   bbspi_req_if.sink   req_ch,
   bbspi_rsp_if.source rsp_ch,
   bbspi_csr_if.sink   csr_ch
);

   bbspi_pkg::state_type  state_ff;
   bbspi_pkg::state_type  state_in;
   bbspi_pkg::cfg_type    cfg_ff;
   bbspi_pkg::item_type   item_ff;
   bbspi_pkg::result_type result_in;
   bbspi_pkg::result_type rsp_ff;
   logic                  item_valid_ff;
   logic                  rsp_valid_ff;

   logic       req_fire;
   logic       csr_fire;
   logic       advance;
   logic       div_write;
   logic       rem_busy;
   logic       rem_done;
   logic [7:0] rem_value;
   logic [7:0] eff_div;

   // Handshakes and pipeline advance.
   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ch.ready) && !rem_busy;
   assign req_ch.ready = (!item_valid_ff || advance) && !rem_busy;
   assign req_fire  = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = !rem_busy;
   assign csr_fire  = csr_ch.valid && csr_ch.ready;
   assign div_write = csr_fire && (csr_ch.index == bbspi_pkg::CSR_SPI_CLOCK_DIVIDER);
   assign eff_div   = (cfg_ff.spi_clock_divider == 8'd0) ? 8'd1 : cfg_ff.spi_clock_divider;

   // Tick step between the request register and the response register.
   bbspi_step u_step (
      .state_cur (state_ff),
      .cfg       (cfg_ff),
      .item      (item_ff),
      .state_nxt (state_in),
      .result    (result_in)
   );

   // Counter reduction after a divider write.
   bbspi_rem_unit u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (div_write),
      .dividend  (state_ff.div_count),
      .divisor   (csr_ch.data),
      .busy      (rem_busy),
      .done      (rem_done),
      .remainder (rem_value)
   );

   // Control state, sequencer state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= bbspi_pkg::STATE_RESET;
         cfg_ff        <= bbspi_pkg::CFG_RESET;
      end else begin
         if (req_fire) begin
            item_valid_ff <= 1'b1;
         end else if (advance) begin
            item_valid_ff <= 1'b0;
         end

         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (advance) begin
            state_ff <= state_in;
         end else if (rem_done) begin
            state_ff.div_count <= rem_value;
         end

         if (csr_fire) begin
            unique case (csr_ch.index)
               bbspi_pkg::CSR_SPI_CLOCK_DIVIDER: begin
                  cfg_ff.spi_clock_divider <= csr_ch.data;
               end
               bbspi_pkg::CSR_PRE_TRANSFER_ADC_EDGES: begin
                  cfg_ff.pre_transfer_adc_edges <= csr_ch.data[3:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers for the request and the response.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.opcode  <= req_ch.opcode;
         item_ff.channel <= req_ch.channel;
         item_ff.tx_byte <= req_ch.tx_byte;
         item_ff.miso    <= req_ch.miso;
      end
      if (advance) begin
         rsp_ff <= result_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.spi_sck      = rsp_ff.spi_sck;
   assign rsp_ch.adc_sck      = rsp_ff.adc_sck;
   assign rsp_ch.mosi         = rsp_ff.mosi;
   assign rsp_ch.adc_select_n = rsp_ff.adc_select_n;
   assign rsp_ch.rf_select_n  = rsp_ff.rf_select_n;
   assign rsp_ch.busy_res     = rsp_ff.busy_res;
   assign rsp_ch.done_res     = rsp_ff.done_res;
   assign rsp_ch.rx_byte      = rsp_ff.rx_byte;
   assign rsp_ch.bad_channel  = rsp_ff.bad_channel;

   // The tick counter stays below the effective divider once reduced.
   assert property (@(posedge clock) disable iff (reset)
      !rem_busy |-> (state_ff.div_count < eff_div))
      else $error("tick counter not below divider");

   // While idle the SPI clock is stopped and low.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == bbspi_pkg::PHASE_IDLE) |->
         (!state_ff.clock_enable && !state_ff.spi_level))
      else $error("SPI clock running while idle");

   // A finished transfer leaves the ADC deselected and the block idle.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.done_res) |->
         (rsp_ff.adc_select_n && !rsp_ff.busy_res && !rsp_ff.bad_channel))
      else $error("inconsistent completion response");

endmodule

`default_nettype wire
